/* hw/rtl/sgr_pkg.sv */
// Shared types, codes and tables of the SGR attribute decoder.
package sgr_pkg;

  localparam int unsigned PARAM_W = 16;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned FLAGS_W = 8;

  // configuration register indexes
  localparam logic REG_DEFAULT_FG = 1'b0;
  localparam logic REG_DEFAULT_BG = 1'b1;

  localparam logic [COLOR_W-1:0] DEFAULT_FG_RST = 8'd7;
  localparam logic [COLOR_W-1:0] DEFAULT_BG_RST = 8'd0;

  localparam logic [FLAGS_W-1:0] FLAG_BOLD = 8'h01;
  localparam logic [FLAGS_W-1:0] FLAG_DIM  = 8'h02;

  // SGR codes with special handling
  localparam logic [PARAM_W-1:0] CODE_RESET     = 16'd0;
  localparam logic [PARAM_W-1:0] CODE_BOLD      = 16'd1;
  localparam logic [PARAM_W-1:0] CODE_DIM       = 16'd2;
  localparam logic [PARAM_W-1:0] CODE_SET_END   = 16'd10;
  localparam logic [PARAM_W-1:0] CODE_CLR_BASE  = 16'd20;
  localparam logic [PARAM_W-1:0] CODE_NORMAL    = 16'd22;
  localparam logic [PARAM_W-1:0] CODE_CLR_FIRST = 16'd23;
  localparam logic [PARAM_W-1:0] CODE_FG_BASE   = 16'd30;
  localparam logic [PARAM_W-1:0] CODE_FG_EXT    = 16'd38;
  localparam logic [PARAM_W-1:0] CODE_FG_DEF    = 16'd39;
  localparam logic [PARAM_W-1:0] CODE_BG_BASE   = 16'd40;
  localparam logic [PARAM_W-1:0] CODE_BG_EXT    = 16'd48;
  localparam logic [PARAM_W-1:0] CODE_BG_DEF    = 16'd49;
  localparam logic [PARAM_W-1:0] CODE_FGB_BASE  = 16'd90;
  localparam logic [PARAM_W-1:0] CODE_BGB_BASE  = 16'd100;
  localparam logic [PARAM_W-1:0] EXT_MODE_IDX   = 16'd5;
  localparam logic [PARAM_W-1:0] BRIGHT_OFFSET  = 16'd8;
  localparam logic [PARAM_W-1:0] BASE_COUNT     = 16'd8;

  typedef enum logic [2:0] {
    EXT_IDLE  = 3'b001,
    EXT_MODE  = 3'b010,
    EXT_INDEX = 3'b100
  } ext_phase_t;

  typedef struct packed {
    logic [PARAM_W-1:0] value;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] fg;
    logic [FLAGS_W-1:0] flags;
  } attr_t;

  // flag bit selected by the low digit of a set or clear code
  function automatic logic [FLAGS_W-1:0] code_flag(input logic [3:0] d);
    logic [FLAGS_W-1:0] f;
    unique case (d)
      4'd1:    f = 8'h01;
      4'd2:    f = 8'h02;
      4'd3:    f = 8'h04;
      4'd4:    f = 8'h08;
      4'd5:    f = 8'h10;
      4'd7:    f = 8'h20;
      4'd8:    f = 8'h40;
      4'd9:    f = 8'h80;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

endpackage

/* hw/rtl/sgr_in_reg.sv */
// Input register stage of the SGR attribute decoder.
module sgr_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  logic          drain,
  input  sgr_pkg::item_t item_in,
  output logic          valid,
  output sgr_pkg::item_t item_out
);
  import sgr_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (drain) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_in;
    end
  end

  assign valid    = valid_r;
  assign item_out = item_r;

endmodule

/* hw/rtl/sgr_attr_core.sv */
// Attribute state and per-parameter SGR decode.
module sgr_attr_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  sgr_pkg::item_t              item,
  input  logic [sgr_pkg::COLOR_W-1:0] default_fg,
  input  logic [sgr_pkg::COLOR_W-1:0] default_bg,
  output sgr_pkg::attr_t              attr_nxt
);
  import sgr_pkg::*;

  logic [FLAGS_W-1:0] flags_r, flags_nxt;
  logic [COLOR_W-1:0] fg_r, fg_nxt;
  logic [COLOR_W-1:0] bg_r, bg_nxt;
  ext_phase_t         phase_r, phase_nxt;
  logic               is_bg_r, is_bg_nxt;
  logic               mode_ok_r, mode_ok_nxt;

  logic [PARAM_W-1:0] q;
  logic [PARAM_W-1:0] clr_digit;
  logic [PARAM_W-1:0] fg_base, bg_base, fg_bright, bg_bright;

  assign q         = item.value;
  assign clr_digit = q - CODE_CLR_BASE;
  assign fg_base   = q - CODE_FG_BASE;
  assign bg_base   = q - CODE_BG_BASE;
  assign fg_bright = q - CODE_FGB_BASE + BRIGHT_OFFSET;
  assign bg_bright = q - CODE_BGB_BASE + BRIGHT_OFFSET;

  always_comb begin
    flags_nxt   = flags_r;
    fg_nxt      = fg_r;
    bg_nxt      = bg_r;
    phase_nxt   = EXT_IDLE;
    is_bg_nxt   = is_bg_r;
    mode_ok_nxt = mode_ok_r;
    unique case (phase_r)
      EXT_MODE: begin
        mode_ok_nxt = (q == EXT_MODE_IDX);
        phase_nxt   = EXT_INDEX;
      end
      EXT_INDEX: begin
        if (mode_ok_r) begin
          if (is_bg_r) begin
            bg_nxt = q[COLOR_W-1:0];
          end else begin
            fg_nxt = q[COLOR_W-1:0];
          end
        end
      end
      default: begin
        priority if (q == CODE_RESET) begin
          flags_nxt = '0;
          fg_nxt    = default_fg;
          bg_nxt    = default_bg;
        end else if (q == CODE_BOLD) begin
          flags_nxt = (flags_r | FLAG_BOLD) & ~FLAG_DIM;
        end else if (q == CODE_DIM) begin
          flags_nxt = (flags_r | FLAG_DIM) & ~FLAG_BOLD;
        end else if (q < CODE_SET_END) begin
          flags_nxt = flags_r | code_flag(q[3:0]);
        end else if (q == CODE_NORMAL) begin
          flags_nxt = flags_r & ~(FLAG_BOLD | FLAG_DIM);
        end else if (q >= CODE_CLR_FIRST && q < CODE_FG_BASE) begin
          flags_nxt = flags_r & ~code_flag(clr_digit[3:0]);
        end else if (q >= CODE_FG_BASE && q < CODE_FG_EXT) begin
          fg_nxt = fg_base[COLOR_W-1:0];
        end else if (q == CODE_FG_EXT || q == CODE_BG_EXT) begin
          phase_nxt   = EXT_MODE;
          is_bg_nxt   = (q == CODE_BG_EXT);
          mode_ok_nxt = 1'b0;
        end else if (q == CODE_FG_DEF) begin
          fg_nxt = default_fg;
        end else if (q >= CODE_BG_BASE && q < CODE_BG_EXT) begin
          bg_nxt = bg_base[COLOR_W-1:0];
        end else if (q == CODE_BG_DEF) begin
          bg_nxt = default_bg;
        end else if (q >= CODE_FGB_BASE && q < CODE_FGB_BASE + BASE_COUNT) begin
          fg_nxt = fg_bright[COLOR_W-1:0];
        end else if (q >= CODE_BGB_BASE && q < CODE_BGB_BASE + BASE_COUNT) begin
          bg_nxt = bg_bright[COLOR_W-1:0];
        end else begin
          flags_nxt = flags_r;
        end
      end
    endcase
    // drop any pending extended colour at the end of the sequence
    if (item.last) begin
      phase_nxt = EXT_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r   <= '0;
      fg_r      <= DEFAULT_FG_RST;
      bg_r      <= DEFAULT_BG_RST;
      phase_r   <= EXT_IDLE;
      is_bg_r   <= 1'b0;
      mode_ok_r <= 1'b0;
    end else if (step) begin
      flags_r   <= flags_nxt;
      fg_r      <= fg_nxt;
      bg_r      <= bg_nxt;
      phase_r   <= phase_nxt;
      is_bg_r   <= is_bg_nxt;
      mode_ok_r <= mode_ok_nxt;
    end
  end

  assign attr_nxt.flags = flags_nxt;
  assign attr_nxt.fg    = fg_nxt;
  assign attr_nxt.bg    = bg_nxt;

endmodule

/* hw/rtl/sgr_out_reg.sv */
// Result register stage of the SGR attribute decoder.
module sgr_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  sgr_pkg::attr_t attr_in,
  input  logic           ready,
  output logic           valid,
  output sgr_pkg::attr_t attr_out
);
  import sgr_pkg::*;

  logic  valid_r, valid_nxt;
  attr_t attr_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      attr_r <= attr_in;
    end
  end

  assign valid    = valid_r;
  assign attr_out = attr_r;

endmodule

/* hw/rtl/sgr_attribute_decoder.sv */
// Top level of the SGR attribute decoder: ports, defaults and stage control.
//
//   channel  direction  payload
//   in_      slave      tdata[15:0] param_value, tlast last_param
//   out_     master     tdata[7:0] style_flags, [15:8] fg_index, [23:16] bg_index
//   cfg_     write      index 0 default_fg, index 1 default_bg
//
// One transaction per cycle sustained while out_tready stays high; each parameter
// passes the input register, then is decoded into the result register, before
// it reaches out_. The decode updates the attribute state in the same cycle it
// loads the result, so consecutive parameters follow without a bubble.
// rst_n clears both stage valids and restores defaults and attributes.
// A stalled result holds the pipe; in_tready drops while the input stage is
// full and the result waits.
module sgr_attribute_decoder #(
  parameter int unsigned PARAM_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // [15:0] param_value
  input  logic                        in_tlast,   // last_param
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,  // [7:0] flags, [15:8] fg, [23:16] bg
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [sgr_pkg::COLOR_W-1:0] cfg_wdata
);
  import sgr_pkg::*;

  localparam logic [PARAM_W-1:0] PMASK = (PARAM_BITS >= PARAM_W) ? {PARAM_W{1'b1}} :
      PARAM_W'((64'd1 << PARAM_BITS) - 64'd1);

  logic [COLOR_W-1:0] default_fg_r, default_bg_r;
  logic               in_valid, out_valid;
  logic               accept, advance;
  item_t              in_item, stage_item;
  attr_t              attr_nxt, attr_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_fg_r <= DEFAULT_FG_RST;
      default_bg_r <= DEFAULT_BG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEFAULT_FG: default_fg_r <= cfg_wdata;
        REG_DEFAULT_BG: default_bg_r <= cfg_wdata;
        default:        default_fg_r <= default_fg_r;
      endcase
    end
  end

  // advance the staged parameter whenever the result register can take it
  assign advance   = in_valid && (!out_valid || out_tready);
  assign in_tready = !in_valid || advance;
  assign accept    = in_tvalid && in_tready;

  assign in_item.value = in_tdata & PMASK;
  assign in_item.last  = in_tlast;

  sgr_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .drain    (advance),
    .item_in  (in_item),
    .valid    (in_valid),
    .item_out (stage_item)
  );

  sgr_attr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .item       (stage_item),
    .default_fg (default_fg_r),
    .default_bg (default_bg_r),
    .attr_nxt   (attr_nxt)
  );

  sgr_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance),
    .attr_in  (attr_nxt),
    .ready    (out_tready),
    .valid    (out_valid),
    .attr_out (attr_out)
  );

  assign out_tvalid = out_valid;
  assign out_tdata  = {attr_out.bg, attr_out.fg, attr_out.flags};

endmodule

/* hw/rtl/sgr_checker.sv */
// Port-level checks of the SGR attribute decoder, bound to the top level.
module sgr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // bold and dim never show together
  a_bold_dim: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("bold and dim both set");

  // an empty result register never backs up the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with no pending result");

  // a transaction that meets a free pipe shows up after the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> ##1 out_tvalid)
    else $error("result missing after accepted transaction");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind sgr_attribute_decoder sgr_checker u_sgr_checker (.*);
